[rtl/assert_macros.svh]
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[rtl/ufbd_pkg.sv]
`default_nettype none

package ufbd_pkg;

  localparam int BAUD_W     = 24;
  localparam int CLK_W      = 32;
  localparam int DIVL_W     = 17;
  localparam int DEN_W      = 29;
  localparam int DVD_W      = 64;
  localparam int FRAC_SHIFT = 28;
  localparam int CNT_W      = 6;
  localparam int PCT_W      = 8;
  localparam int THR_W      = 7;
  localparam int MV_W       = 4;

  localparam logic [CLK_W-1:0]  CLOCK_RST   = 32'd204000000;
  localparam logic [THR_W-1:0]  MAX_ERR_RST = 7'd3;
  localparam logic [31:0]       ERR_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0]       ERR_HALF    = 32'h8000_0000;
  localparam logic [31:0]       DIV_MAX     = 32'd65536;
  localparam logic [THR_W-1:0]  PCT_SCALE   = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_SAT     = 8'd255;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_DIV   = 2'd1,
    STATUS_ERR_HIGH = 2'd2
  } status_t;

  typedef enum logic {
    CFG_CLOCK_HZ = 1'b0,
    CFG_MAX_ERR  = 1'b1
  } cfg_idx_t;

endpackage

`default_nettype wire

[rtl/uart_fractional_baud_divisor_search.sv]
// The search covers at most 120 pairs with 15 multipliers. A zero baud rate answers
//   on the next cycle.
// Throughput: one transaction at a time; busy stays high until the result strobe.
//   Every quotient goes through one shared 64-step restoring divider, one bit a cycle.
// Reset (rst_n, synchronous): sequencer idles, strobe clears, clock_hz returns to
//   204000000 and max_error_percent to 3. The result strobe cannot be stalled.
`default_nettype none

module uart_fractional_baud_divisor_search #(
  parameter int MAX_MULTIPLIER = 15
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [23:0] in_baud_rate,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [16:0]      out_divisor_latch,
  output logic [3:0]       out_mul_value,
  output logic [3:0]       out_add_value,
  output logic [7:0]       out_error_percent,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int BAUD_W = ufbd_pkg::BAUD_W;
  localparam int CLK_W  = ufbd_pkg::CLK_W;
  localparam int DIVL_W = ufbd_pkg::DIVL_W;
  localparam int DEN_W  = ufbd_pkg::DEN_W;
  localparam int DVD_W  = ufbd_pkg::DVD_W;
  localparam int CNT_W  = ufbd_pkg::CNT_W;
  localparam int PCT_W  = ufbd_pkg::PCT_W;
  localparam int THR_W  = ufbd_pkg::THR_W;
  localparam int MV_W   = ufbd_pkg::MV_W;
  localparam logic [MV_W-1:0]  M_LAST   = MV_W'(MAX_MULTIPLIER);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PAIR, S_DIV, S_EVAL, S_ACT, S_DIFF, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_PAIR, PH_ACT, PH_PCT
  } phase_t;

  state_t                   state_r, state_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [DVD_W-1:0]         dividend_r, dividend_nxt;
  logic [DEN_W-1:0]         divisor_r, divisor_nxt;
  logic [DEN_W-1:0]         rem_r, rem_nxt;
  logic [BAUD_W-1:0]        baud_r, baud_nxt;
  logic [MV_W-1:0]          m_r, m_nxt;
  logic [MV_W-1:0]          d_r, d_nxt;
  logic [31:0]              best_err_r, best_err_nxt;
  logic [DIVL_W-1:0]        best_div_r, best_div_nxt;
  logic [MV_W-1:0]          best_m_r, best_m_nxt;
  logic [MV_W-1:0]          best_d_r, best_d_nxt;
  logic [CLK_W-1:0]         clock_r;
  logic [THR_W-1:0]         max_err_r;
  logic                     out_valid_r, out_valid_nxt;
  ufbd_pkg::status_t        out_status_r, out_status_nxt;
  logic [DIVL_W-1:0]        out_div_r, out_div_nxt;
  logic [MV_W-1:0]          out_m_r, out_m_nxt;
  logic [MV_W-1:0]          out_d_r, out_d_nxt;
  logic [PCT_W-1:0]         out_pct_r, out_pct_nxt;

  // divider step
  logic [DEN_W:0]           r2;
  logic [DEN_W:0]           r2_sub;
  logic                     ge;
  // pair evaluation
  logic [31:0]              q_err, q_div, err_adj, dv_adj;
  logic                     round_up, dv_ok, better, last_pair;
  logic [MV_W:0]            m_sum, best_sum;
  logic [35:0]              num_pair;
  logic [DEN_W-1:0]         den_pair, den_act;
  logic [31:0]              num_act, actual, diff;
  logic [38:0]              num_pct;
  logic [PCT_W-1:0]         pct_sat;

  always_comb begin
    r2     = {rem_r, dividend_r[DVD_W-1]};
    ge     = r2 >= {1'b0, divisor_r};
    r2_sub = r2 - {1'b0, divisor_r};

    q_err    = dividend_r[31:0];
    q_div    = dividend_r[63:32];
    round_up = q_err > ufbd_pkg::ERR_HALF;
    err_adj  = round_up ? (32'd0 - q_err) : q_err;
    dv_adj   = q_div + {31'd0, round_up};
    dv_ok    = (dv_adj != 32'd0) && (dv_adj <= ufbd_pkg::DIV_MAX);
    better   = dv_ok && (err_adj < best_err_r);
    last_pair = (m_r == M_LAST) && (d_r == m_r - MV_W'(1));

    m_sum    = {1'b0, m_r} + {1'b0, d_r};
    best_sum = {1'b0, best_m_r} + {1'b0, best_d_r};
    num_pair = 36'(clock_r) * 36'(m_r);
    den_pair = DEN_W'(baud_r) * DEN_W'(m_sum);
    num_act  = 32'(clock_r[CLK_W-1:4]) * 32'(best_m_r);
    den_act  = DEN_W'(best_div_r) * DEN_W'(best_sum);
    actual   = dividend_r[31:0];
    diff     = (actual > 32'(baud_r)) ? (actual - 32'(baud_r)) : (32'(baud_r) - actual);
    num_pct  = 39'(diff) * 39'(ufbd_pkg::PCT_SCALE);
    pct_sat  = (|dividend_r[DVD_W-1:PCT_W]) ? ufbd_pkg::PCT_SAT : dividend_r[PCT_W-1:0];
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    dividend_nxt   = dividend_r;
    divisor_nxt    = divisor_r;
    rem_nxt        = rem_r;
    baud_nxt       = baud_r;
    m_nxt          = m_r;
    d_nxt          = d_r;
    best_err_nxt   = best_err_r;
    best_div_nxt   = best_div_r;
    best_m_nxt     = best_m_r;
    best_d_nxt     = best_d_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_div_nxt    = out_div_r;
    out_m_nxt      = out_m_r;
    out_d_nxt      = out_d_r;
    out_pct_nxt    = out_pct_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          baud_nxt     = in_baud_rate;
          m_nxt        = MV_W'(1);
          d_nxt        = '0;
          best_err_nxt = ufbd_pkg::ERR_INIT;
          best_div_nxt = '0;
          best_m_nxt   = '0;
          best_d_nxt   = '0;
          if (in_baud_rate == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ufbd_pkg::STATUS_NO_DIV;
            out_div_nxt    = '0;
            out_m_nxt      = '0;
            out_d_nxt      = '0;
            out_pct_nxt    = '0;
          end else begin
            state_nxt = S_PAIR;
          end
        end
      end
      S_PAIR: begin
        dividend_nxt = {num_pair, {ufbd_pkg::FRAC_SHIFT{1'b0}}};
        divisor_nxt  = den_pair;
        rem_nxt      = '0;
        cnt_nxt      = '0;
        phase_nxt    = PH_PAIR;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        dividend_nxt = {dividend_r[DVD_W-2:0], ge};
        rem_nxt      = ge ? r2_sub[DEN_W-1:0] : r2[DEN_W-1:0];
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          case (phase_r)
            PH_PAIR: state_nxt = S_EVAL;
            PH_ACT:  state_nxt = S_DIFF;
            PH_PCT:  state_nxt = S_DONE;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EVAL: begin
        if (better) begin
          best_err_nxt = err_adj;
          best_div_nxt = dv_adj[DIVL_W-1:0];
          best_m_nxt   = m_r;
          best_d_nxt   = d_r;
        end
        // exact hit ends the search early
        if (last_pair || (better && err_adj == 32'd0)) begin
          state_nxt = S_ACT;
        end else begin
          state_nxt = S_PAIR;
          if (d_r == m_r - MV_W'(1)) begin
            m_nxt = m_r + MV_W'(1);
            d_nxt = '0;
          end else begin
            d_nxt = d_r + MV_W'(1);
          end
        end
      end
      S_ACT: begin
        if (best_div_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ufbd_pkg::STATUS_NO_DIV;
          out_div_nxt    = '0;
          out_m_nxt      = '0;
          out_d_nxt      = '0;
          out_pct_nxt    = '0;
          state_nxt      = S_IDLE;
        end else begin
          dividend_nxt = 64'(num_act);
          divisor_nxt  = den_act;
          rem_nxt      = '0;
          cnt_nxt      = '0;
          phase_nxt    = PH_ACT;
          state_nxt    = S_DIV;
        end
      end
      S_DIFF: begin
        dividend_nxt = 64'(num_pct);
        divisor_nxt  = DEN_W'(baud_r);
        rem_nxt      = '0;
        cnt_nxt      = '0;
        phase_nxt    = PH_PCT;
        state_nxt    = S_DIV;
      end
      S_DONE: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = (pct_sat < PCT_W'(max_err_r)) ? ufbd_pkg::STATUS_OK
                                                       : ufbd_pkg::STATUS_ERR_HIGH;
        out_div_nxt    = best_div_r;
        out_m_nxt      = best_m_r;
        out_d_nxt      = best_d_r;
        out_pct_nxt    = pct_sat;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_PAIR;
      out_valid_r <= 1'b0;
      clock_r     <= ufbd_pkg::CLOCK_RST;
      max_err_r   <= ufbd_pkg::MAX_ERR_RST;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (ufbd_pkg::cfg_idx_t'(cfg_index))
          ufbd_pkg::CFG_CLOCK_HZ: clock_r   <= cfg_data;
          ufbd_pkg::CFG_MAX_ERR:  max_err_r <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
    end
    cnt_r        <= cnt_nxt;
    dividend_r   <= dividend_nxt;
    divisor_r    <= divisor_nxt;
    rem_r        <= rem_nxt;
    baud_r       <= baud_nxt;
    m_r          <= m_nxt;
    d_r          <= d_nxt;
    best_err_r   <= best_err_nxt;
    best_div_r   <= best_div_nxt;
    best_m_r     <= best_m_nxt;
    best_d_r     <= best_d_nxt;
    out_status_r <= out_status_nxt;
    out_div_r    <= out_div_nxt;
    out_m_r      <= out_m_nxt;
    out_d_r      <= out_d_nxt;
    out_pct_r    <= out_pct_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_divisor_latch = out_div_r;
  assign out_mul_value     = out_m_r;
  assign out_add_value     = out_d_r;
  assign out_error_percent = out_pct_r;

`include "assert_macros.svh"

  // a result strobe never overlaps an active search
  `ASSERT_CLK(a_strobe_idle, clk, rst_n, out_valid |-> !busy, "strobe during search")
  `ASSERT_CLK(a_start_busy, clk, rst_n, (start && !busy && in_baud_rate != '0) |=> busy, "start not taken")
  `ASSERT_CLK(a_no_div_zero, clk, rst_n, (out_valid && out_status == ufbd_pkg::STATUS_NO_DIV) |-> (out_divisor_latch == '0 && out_mul_value == '0 && out_error_percent == '0), "no-divisor result not cleared")
  `ASSERT_CLK(a_found_pair, clk, rst_n, (out_valid && out_status != ufbd_pkg::STATUS_NO_DIV) |-> (out_divisor_latch != '0 && out_mul_value != '0 && out_add_value < out_mul_value), "bad divider pair")
  `ASSERT_ALWAYS(a_div_phase, clk, (state_r == S_DIV) |-> (phase_r == PH_PAIR || phase_r == PH_ACT || phase_r == PH_PCT), "divider phase lost")

endmodule

`default_nettype wire

[test/tb_uart_fractional_baud_divisor_search.sv]
`default_nettype none

module tb_uart_fractional_baud_divisor_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 20;
  localparam int RST_CYCLES = 12;
  localparam int MAX_MUL = 15;
  localparam int PHASES = 4;
  localparam int ITEMS_PER_PHASE = 25;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    ufbd_pkg::status_t status;
    logic [16:0] divisor_latch;
    logic [3:0]  mul_value;
    logic [3:0]  add_value;
    logic [7:0]  error_percent;
  } baud_setting_t;

  class baud_search_scoreboard;
    logic [31:0]   clock_hz = ufbd_pkg::CLOCK_RST;
    logic [6:0]    max_err_pct = ufbd_pkg::MAX_ERR_RST;
    baud_setting_t settings_due[$];
    int            failures = 0;

    function baud_setting_t search_divisor(logic [23:0] baud);
      baud_setting_t r;
      logic [31:0] best_err, err;
      logic [16:0] best_div;
      logic [3:0]  best_m, best_d;
      logic [63:0] num, den, q, dv, actual, diff, pct;
      bit          exact;
      r = '{ufbd_pkg::STATUS_NO_DIV, 17'd0, 4'd0, 4'd0, 8'd0};
      best_err = ufbd_pkg::ERR_INIT;
      best_div = '0;
      best_m = '0;
      best_d = '0;
      exact = 1'b0;
      if (baud == '0) return r;
      for (int m = 1; m <= MAX_MUL && !exact; m++) begin
        for (int d = 0; d < m && !exact; d++) begin
          num = 64'(clock_hz) * 64'(m);
          den = 64'(baud) * 64'(m + d);
          // num < 2^36, so the shift cannot overflow 64 bits
          q = (num << ufbd_pkg::FRAC_SHIFT) / den;
          err = q[31:0];
          dv = q >> 32;
          if (err > ufbd_pkg::ERR_HALF) begin
            err = 32'd0 - err;
            dv = dv + 64'd1;
          end
          if (dv >= 64'd1 && dv <= 64'(ufbd_pkg::DIV_MAX) && err < best_err) begin
            best_err = err;
            best_div = dv[16:0];
            best_m = 4'(m);
            best_d = 4'(d);
            if (err == '0) exact = 1'b1;
          end
        end
      end
      if (best_div == '0) return r;
      actual = (64'(clock_hz >> 4) * 64'(best_m)) /
               (64'(best_div) * (64'(best_m) + 64'(best_d)));
      diff = (actual > 64'(baud)) ? actual - 64'(baud) : 64'(baud) - actual;
      pct = (diff * 64'd100) / 64'(baud);
      if (pct > 64'(ufbd_pkg::PCT_SAT)) pct = 64'(ufbd_pkg::PCT_SAT);
      r.status = (pct < 64'(max_err_pct)) ? ufbd_pkg::STATUS_OK : ufbd_pkg::STATUS_ERR_HIGH;
      r.divisor_latch = best_div;
      r.mul_value = best_m;
      r.add_value = best_d;
      r.error_percent = pct[7:0];
      return r;
    endfunction

    function void note_request(logic [23:0] baud);
      settings_due.push_back(search_divisor(baud));
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [1:0] status, logic [16:0] div, logic [3:0] mul,
                               logic [3:0] add, logic [7:0] pct);
      baud_setting_t e;
      if (settings_due.size() == 0) begin
        $error("result transaction with no request outstanding");
        failures++;
        return;
      end
      e = settings_due.pop_front();
      check_field("status", 32'(e.status), 32'(status));
      check_field("divisor_latch", 32'(e.divisor_latch), 32'(div));
      check_field("mul_value", 32'(e.mul_value), 32'(mul));
      check_field("add_value", 32'(e.add_value), 32'(add));
      check_field("error_percent", 32'(e.error_percent), 32'(pct));
    endfunction

    function int pending();
      return settings_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [23:0] in_baud_rate = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [16:0] out_divisor_latch;
  logic [3:0]  out_mul_value;
  logic [3:0]  out_add_value;
  logic [7:0]  out_error_percent;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = ufbd_pkg::CFG_CLOCK_HZ;
  logic [31:0] cfg_data = '0;

  baud_search_scoreboard sb = new();

  int unsigned std_rates[12] = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600,
                                 115200, 230400, 460800, 921600};

  uart_fractional_baud_divisor_search #(
    .MAX_MULTIPLIER(MAX_MUL)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_baud_rate     (in_baud_rate),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_divisor_latch(out_divisor_latch),
    .out_mul_value    (out_mul_value),
    .out_add_value    (out_add_value),
    .out_error_percent(out_error_percent),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_status, out_divisor_latch, out_mul_value, out_add_value,
                      out_error_percent);
    end
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 300);
    return $urandom_range(0, 3);
  endfunction

  // start is left high after acceptance so back-to-back requests need no re-raise
  task automatic send_request(input logic [23:0] baud, input bit idle_ok);
    int unsigned gap;
    gap = idle_ok ? pick_gap() : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_baud_rate <= baud;
    do @(posedge clk); while (busy);
    sb.note_request(baud);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] clock_word, input logic [31:0] thr_word);
    cfg_valid <= 1'b1;
    cfg_index <= ufbd_pkg::CFG_CLOCK_HZ;
    cfg_data <= clock_word;
    do @(posedge clk); while (!cfg_ready);
    sb.clock_hz = clock_word;
    cfg_index <= ufbd_pkg::CFG_MAX_ERR;
    cfg_data <= thr_word;
    do @(posedge clk); while (!cfg_ready);
    sb.max_err_pct = thr_word[6:0];
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] random_baud(logic [31:0] clock_word);
    logic [31:0] tmp;
    logic [31:0] div;
    int unsigned width;
    case ($urandom_range(0, 9))
      0, 1, 2: tmp = std_rates[$urandom_range(0, 11)];
      3, 4, 5: begin
        // aim near an in-range divisor, with some jitter
        div = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65536) : $urandom_range(1, 200);
        tmp = (clock_word >> 4) / div;
        tmp = tmp + $urandom_range(0, 64) - 32;
      end
      6, 7, 8: begin
        width = $urandom_range(1, 24);
        tmp = $urandom() & ((32'd1 << width) - 1);
      end
      default: tmp = $urandom();
    endcase
    if (tmp[31:24] != '0) tmp = {8'd0, tmp[23:0]};
    if (tmp == '0) tmp = 32'd1;
    return tmp[23:0];
  endfunction

  initial begin
    logic [31:0] clock_word, thr_word;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: typical rates, exact hit, zero baud, both field extremes
    send_request(24'd9600, 1'b1);
    send_request(24'd115200, 1'b0);
    send_request(24'd12750000, 1'b1);
    send_request(24'd1, 1'b0);
    send_request(24'd0, 1'b0);
    send_request(24'hFFFFFF, 1'b1);
    send_request(24'd3000000, 1'b0);
    send_request(24'd921600, 1'b1);
    drain();

    configure(32'hFFFF_FFFF, 32'd100);
    send_request(24'd1, 1'b0);
    send_request(24'hFFFFFF, 1'b1);
    send_request(24'd115200, 1'b0);
    send_request(24'h800000, 1'b0);
    drain();

    configure(32'd1, 32'd0);
    send_request(24'd1, 1'b1);
    send_request(24'hFFFFFF, 1'b0);
    drain();

    // zero clock: nothing can be in range
    configure(32'd0, 32'd50);
    send_request(24'd9600, 1'b0);
    drain();

    // threshold above one hundred, compared unclamped
    configure(ufbd_pkg::CLOCK_RST, 32'd127);
    send_request(24'hFFFFFF, 1'b0);
    send_request(24'd5000000, 1'b1);
    send_request(24'd2000000, 1'b0);
    drain();

    // zero threshold rejects even an exact hit
    configure(32'd48000000, 32'hFFFF_FF80);
    send_request(24'd3000000, 1'b0);
    send_request(24'd115200, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: clock_word = $urandom();
        1: clock_word = $urandom_range(1, 1000000);
        default: begin
          case ($urandom_range(0, 3))
            0: clock_word = 32'd12000000;
            1: clock_word = 32'd48000000;
            2: clock_word = 32'd96000000;
            default: clock_word = ufbd_pkg::CLOCK_RST;
          endcase
        end
      endcase
      thr_word = $urandom();
      thr_word[6:0] = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, 10));
      configure(clock_word, thr_word);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 19) == 0) drain();
        // phase one runs without idling
        send_request(random_baud(clock_word), p != 1);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(100_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/ufbd_pkg.sv
rtl/uart_fractional_baud_divisor_search.sv
test/tb_uart_fractional_baud_divisor_search.sv
